// ===== sv/pss_pkg.sv =====
// Shared types and constants for the phased slot scheduler.
package pss_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PORT_W   = 4;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PORT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNCONN    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CTX_SMALL = 3'd6;

  localparam logic REG_PERIOD_LEN = 1'b0;
  localparam logic REG_PORT_MASK  = 1'b1;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [WORD_W-1:0] TICK_RESET  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CYCLE_RESET = 32'd1000;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== sv/phased_slot_scheduler.sv =====
// Top level of the phased slot scheduler: slot table, sequencer and shared divider.
//
// channel   dir  handshake         payload
// s_axis    in   tvalid/tready     tdata: item fields, tuser: operation
// m_axis    out  tvalid/tready     tdata: result fields
// cfg       in   cfg_we            cfg_index, cfg_data
//
// An item holds the block from its transfer in to its result transfer. A rejected
// register item or a tick goes straight to its result; a sequential context scans
// every slot in use (port scan); a counted context or a tick that dispatches a
// counted entry waits for the 32-step shared divider. The block returns to idle before the next transfer in.
// Reset is synchronous; slot storage is not cleared. tready is low while an item
// is in work or a result is unsent; m_axis_tready low holds the result.
module phased_slot_scheduler
  import pss_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 32,
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // port[3:0], start_req[35:4], start_default[36], length[68:37],
  // context_req[100:69], context_default[101], zero fill to 104
  input  logic [103:0] s_axis_tdata,
  // operation
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dispatch_valid[0], dispatch_port[4:1], dispatch_context[36:5],
  // missed_valid[37], missed_port[41:38], missed_start[73:42],
  // missed_length[105:74], overrun_ticks[137:106], register_status[140:138]
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_TICK  = 7'b0010000,
    S_TDIV  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [PORT_W-1:0] mem_port    [MAX_SLOTS];
  logic [WORD_W-1:0] mem_start   [MAX_SLOTS];
  logic [WORD_W-1:0] mem_length  [MAX_SLOTS];
  logic [WORD_W-1:0] mem_context [MAX_SLOTS];
  logic              mem_counted [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] running;

  logic [CNT_W-1:0]  slots_used, current_slot, scan;
  logic [WORD_W-1:0] tick_count, last_start_tick, last_cycle_tick, cycle_number;
  logic [WORD_W-1:0] period_len;
  logic [15:0]       port_mask;

  logic [PORT_W-1:0] in_port;
  logic [WORD_W-1:0] in_start, in_len, in_ctx, value;
  logic              in_sdef, in_cdef;

  logic [143:0] result;
  logic [WORD_W-1:0] prev_start, prev_len;
  logic [IDX_W-1:0]  prev_idx, scan_idx, used_idx;

  div_req_t dreq;
  div_rsp_t drsp;

  pss_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = result;

  assign prev_idx = IDX_W'(slots_used - CNT_W'(1));
  assign scan_idx = IDX_W'(scan);
  assign used_idx = IDX_W'(slots_used);
  assign prev_start = mem_start[prev_idx];
  assign prev_len   = mem_length[prev_idx];

  // registration check chain
  logic [WORD_W:0]   pend, eff_end;
  logic [WORD_W-1:0] eff_start;
  logic [STATUS_W-1:0] chk;
  always_comb begin
    pend      = {1'b0, prev_start} + {1'b0, prev_len};
    eff_start = in_start;
    chk       = ST_OK;
    if (in_sdef) eff_start = (slots_used != '0) ? pend[WORD_W-1:0] : '0;
    eff_end = {1'b0, eff_start} + {1'b0, in_len};
    if (period_len == '0) chk = ST_BEYOND;
    else if (slots_used == CNT_W'(MAX_SLOTS)) chk = ST_FULL;
    else if (slots_used != '0 && !in_sdef &&
             !(prev_start < in_start && pend <= {1'b0, in_start})) chk = ST_ORDER;
    else if (32'(in_port) >= NUM_PORTS) chk = ST_BAD_PORT;
    else if (!port_mask[in_port]) chk = ST_UNCONN;
    else if (eff_end > {1'b0, period_len}) chk = ST_BEYOND;
    else if (!in_cdef && in_ctx <= period_len) chk = ST_CTX_SMALL;
  end

  // tick evaluation, using state after cycle rollover
  logic [WORD_W-1:0] now, el, exec, c_last;
  logic [CNT_W-1:0]  c_cur;
  logic              roll, fin, missed, disp;
  logic [IDX_W-1:0]  fidx, didx;
  logic [CNT_W-1:0]  next_cur;
  always_comb begin
    now    = tick_count;
    roll   = (now - last_cycle_tick) >= period_len && current_slot == slots_used;
    c_cur  = roll ? '0 : current_slot;
    c_last = roll ? now : last_cycle_tick;
    fidx   = IDX_W'(c_cur);
    fin    = c_cur < slots_used && running[fidx];
    exec   = now - last_start_tick;
    missed = fin && exec > mem_length[fidx];
    next_cur = fin ? c_cur + CNT_W'(1) : c_cur;
    didx   = IDX_W'(next_cur);
    el     = now - c_last;
    disp   = !missed && next_cur < slots_used && mem_start[didx] <= el &&
             !(running[didx] && !(fin && didx == fidx));
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state           <= S_IDLE;
      running         <= '0;
      slots_used      <= '0;
      current_slot    <= '0;
      tick_count      <= TICK_RESET;
      last_start_tick <= '0;
      last_cycle_tick <= '0;
      cycle_number    <= '0;
      period_len      <= CYCLE_RESET;
      port_mask       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_LEN: period_len <= cfg_data;
          REG_PORT_MASK:  port_mask  <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_port  <= s_axis_tdata[3:0];
            in_start <= s_axis_tdata[35:4];
            in_sdef  <= s_axis_tdata[36];
            in_len   <= s_axis_tdata[68:37];
            in_ctx   <= s_axis_tdata[100:69];
            in_cdef  <= s_axis_tdata[101];
            result   <= '0;
            if (s_axis_tuser[0] == OP_TICK) begin
              tick_count <= tick_count + 32'd1;
              state      <= S_TICK;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          result[140:138] <= chk;
          in_start        <= eff_start;
          if (chk != ST_OK) begin
            state <= S_OUT;
          end else if (in_cdef) begin
            value <= '0;
            scan  <= '0;
            state <= S_SCAN;
          end else begin
            dreq.dividend <= in_ctx;
            dreq.divisor  <= period_len;
            dreq.start    <= 1'b1;
            state         <= S_DIV;
          end
        end
        S_SCAN: begin
          if (scan == slots_used) begin
            mem_port[used_idx]    <= in_port;
            mem_start[used_idx]   <= in_start;
            mem_length[used_idx]  <= in_len;
            mem_context[used_idx] <= value;
            mem_counted[used_idx] <= 1'b0;
            running[used_idx]     <= 1'b0;
            slots_used            <= slots_used + CNT_W'(1);
            state                 <= S_OUT;
          end else begin
            if (mem_port[scan_idx] == in_port) value <= mem_context[scan_idx] + 32'd1;
            scan <= scan + CNT_W'(1);
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            mem_port[used_idx]    <= in_port;
            mem_start[used_idx]   <= in_start;
            mem_length[used_idx]  <= in_len;
            mem_context[used_idx] <= drsp.quotient;
            mem_counted[used_idx] <= 1'b1;
            running[used_idx]     <= 1'b0;
            slots_used            <= slots_used + CNT_W'(1);
            state                 <= S_OUT;
          end
        end
        S_TICK: begin
          if (roll) begin
            last_cycle_tick <= now;
            cycle_number    <= cycle_number + 32'd1;
          end
          current_slot <= next_cur;
          if (fin) running[fidx] <= 1'b0;
          if (missed) begin
            result[37]      <= 1'b1;
            result[41:38]   <= mem_port[fidx];
            result[73:42]   <= mem_start[fidx];
            result[105:74]  <= mem_length[fidx];
            result[137:106] <= exec - mem_length[fidx];
          end
          state <= S_OUT;
          if (disp) begin
            running[didx]   <= 1'b1;
            last_start_tick <= now;
            result[0]       <= 1'b1;
            result[4:1]     <= mem_port[didx];
            if (mem_counted[didx] && mem_context[didx] != '0) begin
              dreq.dividend <= roll ? cycle_number + 32'd1 : cycle_number;
              dreq.divisor  <= mem_context[didx];
              dreq.start    <= 1'b1;
              state         <= S_TDIV;
            end else begin
              result[36:5] <= mem_counted[didx] ? '0 : mem_context[didx];
            end
          end
        end
        S_TDIV: begin
          if (drsp.done) begin
            result[36:5] <= drsp.remainder;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pss_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module pss_divider
  import pss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [WORD_W-1:0] quo, rem, dsr;
  logic [5:0]        cnt;
  logic              busy;
  logic              done;
  logic [WORD_W:0]   trial;

  assign trial = {rem, quo[WORD_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(WORD_W);
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        if (trial[WORD_W]) begin
          rem <= {rem[WORD_W-2:0], quo[WORD_W-1]};
          quo <= {quo[WORD_W-2:0], 1'b0};
        end else begin
          rem <= trial[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};

endmodule
